// File: design/ffsa_pkg.sv
`default_nettype none
package ffsa_pkg;
    localparam int OFFSET_BITS = 16;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_MERGE = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    localparam logic [1:0] REG_ARENA = 2'd0;

    // one table entry
    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] size;
        logic                   free;
    } t_seg;

    // controller -> datapath
    typedef struct packed {
        logic init;      // load table with one free segment
        logic start;     // latch the incoming item
        logic rd;        // read entry at scan / merge position
        logic adv;       // step scan position
        logic take;      // scan hit: write used entry or set free flag
        logic rd_sh;     // read entry below shift position
        logic sh_wr;     // write it one place up
        logic split;     // write free remainder after the used entry
        logic m_step;    // one merge step on the entry just read
        logic m_fin;     // flush merge accumulator, set new count
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic hit;        // entry just read matches
        logic last;       // scan is at the last entry
        logic full;       // table full
        logic sh_done;    // insertion shifting finished
        logic m_end;      // merge read past the last entry
    } t_sts;
endpackage
`default_nettype wire

// File: design/ffsa_datapath.sv
`default_nettype none
module ffsa_datapath import ffsa_pkg::*; #(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic                   i_clk,
    input  wire logic [15:0]            i_arena,
    input  wire logic [1:0]             i_command,
    input  wire logic [15:0]            i_request_bytes,
    input  wire logic [15:0]            i_payload_offset,
    input  wire t_ctl                   i_ctl,
    output t_sts                        o_sts,
    output logic [15:0]                 o_granted
);
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int OW = OFFSET_BITS;

    // segment table: one read and one write per cycle, registered read data
    t_seg          r_mem [MAX_SEGMENTS];
    t_seg          r_q;
    t_seg          r_acc;   // merge accumulator
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;   // scan / merge read position
    logic [CW-1:0] r_sh;    // shift position
    logic [CW-1:0] r_wp;    // merge write position
    logic [1:0]    r_cmd;
    logic [OW:0]   r_need;
    logic [15:0]   r_req;
    logic [15:0]   r_off;
    logic [OW-1:0] r_rem_start, r_rem_size;

    logic          we;
    logic [IW-1:0] wa, ra;
    t_seg          wd;
    logic [CW-1:0] idx_inc;

    assign idx_inc = r_idx + 1'b1;
    assign ra = i_ctl.rd_sh ? IW'(r_sh - 1'b1) : r_idx[IW-1:0];

    always_comb begin
        o_sts.last    = (idx_inc >= r_count);
        o_sts.full    = (r_count >= CW'(MAX_SEGMENTS));
        o_sts.sh_done = (r_sh <= idx_inc);
        o_sts.m_end   = (r_idx >= r_count);
        if (r_cmd == CMD_ALLOC)
            o_sts.hit = r_q.free && ({1'b0, r_q.size} > r_need);
        else
            o_sts.hit = ((OW+1)'(r_q.start) + (OW+1)'(HEADER_BYTES)) == (OW+1)'(r_off);
    end

    // single write port
    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        if (i_ctl.init) begin
            we      = 1'b1;
            wd.size = (i_arena > 16'(HEADER_BYTES)) ?
                      OW'(i_arena - 16'(HEADER_BYTES)) : '0;
            wd.free = 1'b1;
        end else if (i_ctl.take) begin
            we       = 1'b1;
            wa       = r_idx[IW-1:0];
            wd.start = r_q.start;
            if (r_cmd == CMD_ALLOC) begin
                wd.size = OW'(r_req);
                wd.free = 1'b0;
            end else begin
                wd.size = r_q.size;
                wd.free = 1'b1;
            end
        end else if (i_ctl.sh_wr) begin
            we = 1'b1;
            wa = r_sh[IW-1:0];
            wd = r_q;
        end else if (i_ctl.split) begin
            we       = 1'b1;
            wa       = IW'(idx_inc);
            wd.start = r_rem_start;
            wd.size  = r_rem_size;
            wd.free  = 1'b1;
        end else if (i_ctl.m_step) begin
            // flush the run when it ends
            we = (r_idx != '0) && !(r_acc.free && r_q.free);
            wa = r_wp[IW-1:0];
            wd = r_acc;
        end else if (i_ctl.m_fin) begin
            we = 1'b1;
            wa = r_wp[IW-1:0];
            wd = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (i_ctl.rd || i_ctl.rd_sh) r_q <= r_mem[ra];
        if (i_ctl.init) r_count <= CW'(1);
        if (i_ctl.start) begin
            r_cmd   <= i_command;
            r_req   <= i_request_bytes;
            r_off   <= i_payload_offset;
            r_need  <= (OW+1)'(i_request_bytes) + (OW+1)'(HEADER_BYTES);
            r_idx   <= '0;
            r_sh    <= r_count;
            r_wp    <= '0;
        end
        if (i_ctl.adv) r_idx <= idx_inc;
        if (i_ctl.take && r_cmd == CMD_ALLOC) begin
            o_granted   <= 16'(r_q.start + OW'(HEADER_BYTES));
            r_rem_start <= OW'(r_q.start + r_need[OW-1:0]);
            r_rem_size  <= OW'(r_q.size - r_need[OW-1:0]);
        end
        if (i_ctl.sh_wr) r_sh <= r_sh - 1'b1;
        if (i_ctl.split) r_count <= r_count + 1'b1;
        if (i_ctl.m_step) begin
            r_idx <= idx_inc;
            if (r_idx == '0) begin
                r_acc <= r_q;
            end else if (r_acc.free && r_q.free) begin
                // absorb the entry and its header
                r_acc.size <= OW'(r_acc.size + OW'(HEADER_BYTES) + r_q.size);
            end else begin
                r_wp  <= r_wp + 1'b1;
                r_acc <= r_q;
            end
        end
        if (i_ctl.m_fin) r_count <= r_wp + 1'b1;
    end
endmodule
`default_nettype wire

// File: design/ffsa_ctrl.sv
`default_nettype none
module ffsa_ctrl import ffsa_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_command,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_status,
    output logic            o_zero_grant,
    input  wire t_sts       i_sts,
    output t_ctl            o_ctl
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD    = 8'b0000_0010,
        S_CHK   = 8'b0000_0100,
        S_SH_RD = 8'b0000_1000,
        S_SH_WR = 8'b0001_0000,
        S_M_RD  = 8'b0010_0000,
        S_M_CHK = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_cmd;
    logic [1:0] r_status, n_status;
    logic r_zero, n_zero;
    logic take;

    assign o_stall = (r_state != S_IDLE);
    assign take = i_valid && (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_zero_grant = r_zero;

    always_comb begin
        n_state = r_state;
        n_status = r_status;
        n_zero = r_zero;
        o_ctl = '0;
        o_ctl.init = i_cfg_wr;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    o_ctl.start = 1'b1;
                    n_status = ST_OK;
                    n_zero = 1'b1;
                    case (i_command)
                        CMD_ALLOC, CMD_FREE: n_state = S_RD;
                        CMD_MERGE: n_state = S_M_RD;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_RD: begin
                o_ctl.rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.hit) begin
                    if (r_cmd == CMD_ALLOC) begin
                        if (i_sts.full) begin
                            n_status = ST_FULL;
                            n_state = S_OUT;
                        end else begin
                            o_ctl.take = 1'b1;
                            n_zero = 1'b0;
                            n_state = S_SH_RD;
                        end
                    end else begin
                        o_ctl.take = 1'b1;
                        n_state = S_OUT;
                    end
                end else if (i_sts.last) begin
                    n_status = (r_cmd == CMD_ALLOC) ? ST_NO_FIT : ST_BAD_FREE;
                    n_state = S_OUT;
                end else begin
                    o_ctl.adv = 1'b1;
                    n_state = S_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.sh_done) begin
                    o_ctl.split = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_ctl.rd_sh = 1'b1;
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_ctl.sh_wr = 1'b1;
                n_state = S_SH_RD;
            end
            S_M_RD: begin
                if (i_sts.m_end) begin
                    o_ctl.m_fin = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_ctl.rd = 1'b1;
                    n_state = S_M_CHK;
                end
            end
            S_M_CHK: begin
                o_ctl.m_step = 1'b1;
                n_state = S_M_RD;
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_status <= ST_OK;
            r_zero <= 1'b1;
            r_cmd <= CMD_NOP;
        end else begin
            r_state <= n_state;
            r_status <= n_status;
            r_zero <= n_zero;
            if (take) r_cmd <= i_command;
        end
    end
endmodule
`default_nettype wire

// File: design/first_fit_segment_allocator_top.sv
`default_nettype none
// channel | valid   | stall   | payload
// in      | i_valid | o_stall | i_command, i_request_bytes, i_payload_offset
// out     | o_valid | i_stall | o_status, o_granted_offset
// cfg     | APB     | -       | reg 0 arena_bytes at 0x0
//
// One item at a time; the table is a memory with registered reads, so each
// entry is first read and then checked in a state of its own. A successful
// allocate runs scan, shift and split; a failed one ends after the scan.
// Reset (sync, active low) and any arena write reload one free segment.
// o_stall is high from acceptance until the result transfer completes.
module first_fit_segment_allocator_top import ffsa_pkg::*; #(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_request_bytes,
    input  wire logic [15:0] i_payload_offset,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_granted_offset
);
    logic [15:0] r_arena;
    logic cfg_wr, arena_wr;
    t_ctl ctl;
    t_sts sts;
    logic zero_grant;
    logic [15:0] granted;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign arena_wr = cfg_wr && (paddr == REG_ARENA);
    assign prdata = (paddr == REG_ARENA) ? {16'd0, r_arena} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_arena <= 16'd4096;
        else if (arena_wr) r_arena <= pwdata[15:0];
    end

    // init loads from the arena value; on reset use the reset size
    logic [15:0] init_arena;
    assign init_arena = (!i_rst_n) ? 16'd4096 : pwdata[15:0];

    ffsa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr(arena_wr || !i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_command(i_command),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_zero_grant(zero_grant), .i_sts(sts), .o_ctl(ctl)
    );

    ffsa_datapath #(
        .MAX_SEGMENTS(MAX_SEGMENTS), .HEADER_BYTES(HEADER_BYTES)
    ) u_dp (
        .i_clk(i_clk), .i_arena(init_arena), .i_command(i_command),
        .i_request_bytes(i_request_bytes), .i_payload_offset(i_payload_offset),
        .i_ctl(ctl), .o_sts(sts), .o_granted(granted)
    );

    assign o_granted_offset = zero_grant ? 16'd0 : granted;

    // a failed allocate never reports a granted offset
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_granted_offset == 16'd0))
        else $error("nonzero grant on failure");
    // the result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status)))
        else $error("result dropped under stall");
    // no input is taken while a result is pending
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");
endmodule
`default_nettype wire
